// ===== design/axis_angle_vector_rotation_assert.svh =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_assert.svh
// assertion macros used by the rotation pipeline
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define AAVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define AAVR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg
// types and constants of the axis-angle vector rotation pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aavr_pkg;

    // arctangent table length, caps the number of cordic steps
    localparam int ATAN_COUNT = 24;

    // cordic datapath widths
    localparam int XW = 33;   // x and y, q.30 with headroom
    localparam int ZW = 32;   // residual angle, q.28
    localparam int CW = 19;   // cosine, sine and 1 - cos in q.16
    localparam int MW = 29;   // matrix entries in q.24

    // angle constants in q.28, cordic gain in q.30
    localparam logic signed [XW-1:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [XW-1:0] ANG_HALF_PI = 33'sd421657428;
    localparam logic signed [XW-1:0] ANG_TWO_PI  = 33'sd1686629713;
    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) in q.28, rounded to nearest
    localparam logic signed [ZW-1:0] ATAN_Q28 [0:ATAN_COUNT-1] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    // operands that ride along the cordic stages
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               flip;
    } t_carry;

endpackage

// ===== design/axis_angle_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// rotates a vector about a unit axis by an angle (rodrigues formula)
// ----------------------------------------------------------------------------
// One transaction in and one out per clock. The pipeline holds one angle
// reduction stage, one stage per cordic step (CORDIC_STEPS, capped at 24),
// then rounding, axis products, matrix entries, matrix-vector products and
// the rounded, saturated sum, which is the output register. The whole pipeline
// advances together; when the output holds a result that is not taken, the
// pipeline and the input stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "axis_angle_vector_rotation_assert.svh"

module axis_angle_vector_rotation #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, angle
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // rot_x, rot_y, rot_z
    output logic [95:0]  o_m_axis_tdata
);
    import aavr_pkg::*;

    localparam int N = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;

    logic w_en;
    logic w_in_acc;

    // pipeline enable and input handshake
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_in_acc        = i_s_axis_tvalid && w_en;

    // input unpacking
    t_carry                 n_car;
    logic signed [15:0]     w_angle;
    logic signed [XW-1:0]   n_a0;
    logic signed [XW-1:0]   n_a1;
    logic signed [XW-1:0]   n_a2;
    logic                   n_flip;

    assign n_car.ax = $signed(i_s_axis_tdata[15:0]);
    assign n_car.ay = $signed(i_s_axis_tdata[31:16]);
    assign n_car.az = $signed(i_s_axis_tdata[47:32]);
    assign n_car.vx = $signed(i_s_axis_tdata[79:48]);
    assign n_car.vy = $signed(i_s_axis_tdata[111:80]);
    assign n_car.vz = $signed(i_s_axis_tdata[143:112]);
    assign n_car.flip = n_flip;
    assign w_angle  = $signed(i_s_axis_tdata[159:144]);

    // angle reduction into [-pi/2, pi/2], cosine flips outside
    always_comb begin
        n_a0 = $signed({w_angle[15], w_angle, 16'b0});
        priority if (n_a0 > ANG_PI) begin
            n_a1 = n_a0 - ANG_TWO_PI;
        end else if (n_a0 < -ANG_PI) begin
            n_a1 = n_a0 + ANG_TWO_PI;
        end else begin
            n_a1 = n_a0;
        end
        priority if (n_a1 > ANG_HALF_PI) begin
            n_a2   = ANG_PI - n_a1;
            n_flip = 1'b1;
        end else if (n_a1 < -ANG_HALF_PI) begin
            n_a2   = -ANG_PI - n_a1;
            n_flip = 1'b1;
        end else begin
            n_a2   = n_a1;
            n_flip = 1'b0;
        end
    end

    // cordic stage registers, index 0 is the reduction stage
    logic                 r_cv  [0:N];
    logic signed [XW-1:0] r_cx  [0:N];
    logic signed [XW-1:0] r_cy  [0:N];
    logic signed [ZW-1:0] r_cz  [0:N];
    t_carry               r_car [0:N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cx[0]  <= CORDIC_GAIN;
            r_cy[0]  <= '0;
            r_cz[0]  <= n_a2[ZW-1:0];
            r_car[0] <= n_car;
        end
    end

    // one rotation step per stage
    for (genvar k = 1; k <= N; k++) begin : g_cordic
        logic signed [XW-1:0] n_dx;
        logic signed [XW-1:0] n_dy;
        assign n_dx = r_cy[k-1] >>> (k - 1);
        assign n_dy = r_cx[k-1] >>> (k - 1);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!r_cz[k-1][ZW-1]) begin
                    r_cx[k] <= r_cx[k-1] - n_dx;
                    r_cy[k] <= r_cy[k-1] + n_dy;
                    r_cz[k] <= r_cz[k-1] - ATAN_Q28[k-1];
                end else begin
                    r_cx[k] <= r_cx[k-1] + n_dx;
                    r_cy[k] <= r_cy[k-1] - n_dy;
                    r_cz[k] <= r_cz[k-1] + ATAN_Q28[k-1];
                end
                r_car[k] <= r_car[k-1];
            end
        end
    end

    // cosine and sine rounded to q.16, axis outer products
    logic signed [XW-1:0] n_xr;
    logic signed [XW-1:0] n_yr;
    logic signed [CW-1:0] n_c;
    logic signed [CW-1:0] n_s;
    logic                 r_v_cs;
    logic signed [CW-1:0] r_c;
    logic signed [CW-1:0] r_s;
    logic signed [CW-1:0] r_omc;
    logic signed [31:0]   r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    t_carry               r_car_cs;

    assign n_xr = (r_cx[N] + 33'sd8192) >>> 14;
    assign n_yr = (r_cy[N] + 33'sd8192) >>> 14;
    assign n_c  = r_car[N].flip ? -n_xr[CW-1:0] : n_xr[CW-1:0];
    assign n_s  = n_yr[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c      <= n_c;
            r_s      <= n_s;
            r_omc    <= 19'sd65536 - n_c;
            r_pxx    <= r_car[N].ax * r_car[N].ax;
            r_pyy    <= r_car[N].ay * r_car[N].ay;
            r_pzz    <= r_car[N].az * r_car[N].az;
            r_pxy    <= r_car[N].ax * r_car[N].ay;
            r_pxz    <= r_car[N].ax * r_car[N].az;
            r_pyz    <= r_car[N].ay * r_car[N].az;
            r_car_cs <= r_car[N];
        end
    end

    // scaled outer products and sine times axis
    logic                 r_v_l;
    logic signed [50:0]   r_txx, r_tyy, r_tzz, r_txy, r_txz, r_tyz;
    logic signed [34:0]   r_sx, r_sy, r_sz;
    logic signed [CW-1:0] r_c_l;
    t_carry               r_car_l;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_txx   <= r_pxx * r_omc;
            r_tyy   <= r_pyy * r_omc;
            r_tzz   <= r_pzz * r_omc;
            r_txy   <= r_pxy * r_omc;
            r_txz   <= r_pxz * r_omc;
            r_tyz   <= r_pyz * r_omc;
            r_sx    <= r_car_cs.ax * r_s;
            r_sy    <= r_car_cs.ay * r_s;
            r_sz    <= r_car_cs.az * r_s;
            r_c_l   <= r_c;
            r_car_l <= r_car_cs;
        end
    end

    // matrix entries, rounded from q.44 to q.24
    logic signed [51:0]   n_lc, n_lx, n_ly, n_lz;
    logic signed [51:0]   n_s00, n_s01, n_s02, n_s10, n_s11, n_s12;
    logic signed [51:0]   n_s20, n_s21, n_s22;
    logic                 r_v_m;
    logic signed [MW-1:0] r_m00, r_m01, r_m02, r_m10, r_m11, r_m12;
    logic signed [MW-1:0] r_m20, r_m21, r_m22;
    t_carry               r_car_m;

    assign n_lc  = $signed({r_c_l, 28'b0});
    assign n_lx  = $signed({r_sx, 14'b0});
    assign n_ly  = $signed({r_sy, 14'b0});
    assign n_lz  = $signed({r_sz, 14'b0});
    assign n_s00 = (r_txx + n_lc + 52'sd524288) >>> 20;
    assign n_s01 = (r_txy - n_lz + 52'sd524288) >>> 20;
    assign n_s02 = (r_txz + n_ly + 52'sd524288) >>> 20;
    assign n_s10 = (r_txy + n_lz + 52'sd524288) >>> 20;
    assign n_s11 = (r_tyy + n_lc + 52'sd524288) >>> 20;
    assign n_s12 = (r_tyz - n_lx + 52'sd524288) >>> 20;
    assign n_s20 = (r_txz - n_ly + 52'sd524288) >>> 20;
    assign n_s21 = (r_tyz + n_lx + 52'sd524288) >>> 20;
    assign n_s22 = (r_tzz + n_lc + 52'sd524288) >>> 20;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m00   <= n_s00[MW-1:0];
            r_m01   <= n_s01[MW-1:0];
            r_m02   <= n_s02[MW-1:0];
            r_m10   <= n_s10[MW-1:0];
            r_m11   <= n_s11[MW-1:0];
            r_m12   <= n_s12[MW-1:0];
            r_m20   <= n_s20[MW-1:0];
            r_m21   <= n_s21[MW-1:0];
            r_m22   <= n_s22[MW-1:0];
            r_car_m <= r_car_l;
        end
    end

    // matrix times vector products
    logic               r_v_p;
    logic signed [60:0] r_p00, r_p01, r_p02, r_p10, r_p11, r_p12;
    logic signed [60:0] r_p20, r_p21, r_p22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p00 <= r_m00 * r_car_m.vx;
            r_p01 <= r_m01 * r_car_m.vy;
            r_p02 <= r_m02 * r_car_m.vz;
            r_p10 <= r_m10 * r_car_m.vx;
            r_p11 <= r_m11 * r_car_m.vy;
            r_p12 <= r_m12 * r_car_m.vz;
            r_p20 <= r_m20 * r_car_m.vx;
            r_p21 <= r_m21 * r_car_m.vy;
            r_p22 <= r_m22 * r_car_m.vz;
        end
    end

    // row sums, rounded from q.24 and saturated
    logic signed [63:0] n_acc_x, n_acc_y, n_acc_z;
    logic signed [31:0] n_rot_x, n_rot_y, n_rot_z;
    logic               r_v_o;
    logic signed [31:0] r_rot_x, r_rot_y, r_rot_z;

    assign n_acc_x = (r_p00 + r_p01 + r_p02 + 64'sd8388608) >>> 24;
    assign n_acc_y = (r_p10 + r_p11 + r_p12 + 64'sd8388608) >>> 24;
    assign n_acc_z = (r_p20 + r_p21 + r_p22 + 64'sd8388608) >>> 24;

    always_comb begin
        priority if (n_acc_x > 64'sd2147483647)       n_rot_x = 32'sh7fffffff;
        else if (n_acc_x < -64'sd2147483648)          n_rot_x = 32'sh80000000;
        else                                          n_rot_x = n_acc_x[31:0];
        priority if (n_acc_y > 64'sd2147483647)       n_rot_y = 32'sh7fffffff;
        else if (n_acc_y < -64'sd2147483648)          n_rot_y = 32'sh80000000;
        else                                          n_rot_y = n_acc_y[31:0];
        priority if (n_acc_z > 64'sd2147483647)       n_rot_z = 32'sh7fffffff;
        else if (n_acc_z < -64'sd2147483648)          n_rot_z = 32'sh80000000;
        else                                          n_rot_z = n_acc_z[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
            r_rot_z <= n_rot_z;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++) begin
                r_cv[k] <= 1'b0;
            end
            r_v_cs <= 1'b0;
            r_v_l  <= 1'b0;
            r_v_m  <= 1'b0;
            r_v_p  <= 1'b0;
            r_v_o  <= 1'b0;
        end else if (w_en) begin
            r_cv[0] <= w_in_acc;
            for (int k = 1; k <= N; k++) begin
                r_cv[k] <= r_cv[k-1];
            end
            r_v_cs <= r_cv[N];
            r_v_l  <= r_v_cs;
            r_v_m  <= r_v_l;
            r_v_p  <= r_v_m;
            r_v_o  <= r_v_p;
        end
    end

    // output transaction
    assign o_m_axis_tvalid = r_v_o;
    assign o_m_axis_tdata  = {r_rot_z, r_rot_y, r_rot_x};

    // checks
    `AAVR_ASSERT_NEXT(a_in_enters, i_clk, i_rst_n, w_in_acc, r_cv[0])
    `AAVR_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)
    `AAVR_ASSERT_NEXT(a_stall_holds_tail, i_clk, i_rst_n, !w_en,
        r_v_p == $past(r_v_p) && r_v_m == $past(r_v_m))
    `AAVR_ASSERT_NEXT(a_product_moves_out, i_clk, i_rst_n, w_en && r_v_p, r_v_o)

endmodule

// ===== dv/axis_angle_vector_rotation_tb.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_tb
// self-checking bench for the axis-angle vector rotation pipeline
// ----------------------------------------------------------------------------
// Drives directed corner rows and then random rotations through the stream
// input, predicts each rotated vector with an integer model of the cordic and
// rodrigues matrix, and compares results in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_vector_rotation_tb;

    localparam int STEPS      = 16;
    localparam int LATENCY    = STEPS + 6;
    localparam int N_RANDOM   = 700;
    localparam int IDLE_LIMIT = 20000;
    localparam int ATAN_N     = 24;

    localparam longint PI_Q28      = 843314857;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam longint GAIN_Q30    = 652032874;

    localparam longint ATAN_TAB [0:ATAN_N-1] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [31:0] vz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } t_rot_req;

    typedef struct packed {
        logic signed [31:0] rz;
        logic signed [31:0] ry;
        logic signed [31:0] rx;
    } t_rot_res;

    // directed row, optional typed-in result
    typedef struct {
        t_rot_req req;
        bit       known;
        t_rot_res res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, angle
    logic [159:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // rot_x, rot_y, rot_z
    logic [95:0]  o_m_axis_tdata;

    t_rot_res rotated_q[$];
    int       n_fail;
    int       n_in;
    int       n_out;
    int       idle_cycles;
    bit       rx_enable;

    axis_angle_vector_rotation #(.CORDIC_STEPS(STEPS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint floor_shr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint round_half_up(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint rodrigues_entry(longint prod, longint omc, longint lin);
        return round_half_up(prod * omc + lin, 20);
    endfunction

    // rounded, saturated component from a q.24 x vector sum
    function automatic logic [31:0] clamp_component(longint acc);
        longint r;
        r = round_half_up(acc, 24);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    // rotated vector for one request
    function automatic t_rot_res rotate_vector(t_rot_req q);
        longint ax, ay, az, vx, vy, vz, a, x, y, z, dx, dy;
        longint c, s, omc, lc, sx, sy, sz;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        bit flip;
        t_rot_res r;
        ax = q.ax; ay = q.ay; az = q.az;
        vx = q.vx; vy = q.vy; vz = q.vz;
        a = longint'(q.angle) * 65536;
        flip = 0;
        // bring angle into [-pi/2, pi/2]
        if (a > PI_Q28) a -= TWO_PI_Q28;
        else if (a < -PI_Q28) a += TWO_PI_Q28;
        if (a > HALF_PI_Q28) begin
            a = PI_Q28 - a;
            flip = 1;
        end else if (a < -HALF_PI_Q28) begin
            a = -PI_Q28 - a;
            flip = 1;
        end
        // cordic rotation
        x = GAIN_Q30; y = 0; z = a;
        for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = round_half_up(x, 14);
        s = round_half_up(y, 14);
        if (flip) c = -c;
        omc = 65536 - c;
        lc = c <<< 28;
        sx = ax * s * 16384;
        sy = ay * s * 16384;
        sz = az * s * 16384;
        m00 = rodrigues_entry(ax * ax, omc, lc);
        m01 = rodrigues_entry(ax * ay, omc, -sz);
        m02 = rodrigues_entry(ax * az, omc, sy);
        m10 = rodrigues_entry(ax * ay, omc, sz);
        m11 = rodrigues_entry(ay * ay, omc, lc);
        m12 = rodrigues_entry(ay * az, omc, -sx);
        m20 = rodrigues_entry(ax * az, omc, -sy);
        m21 = rodrigues_entry(ay * az, omc, sx);
        m22 = rodrigues_entry(az * az, omc, lc);
        r.rx = clamp_component(m00 * vx + m01 * vy + m02 * vz);
        r.ry = clamp_component(m10 * vx + m11 * vy + m12 * vz);
        r.rz = clamp_component(m20 * vx + m21 * vy + m22 * vz);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] rand_axis();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // send one request, waiting for acceptance
    task automatic send_request(t_rot_req q, t_rot_res res);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= q;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rotated_q.push_back(res);
        n_in++;
        @(negedge i_clk);
    endtask

    // receiver: random stalls, compare each result transaction
    initial begin
        int g;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!rx_enable) begin
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rot_res got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            n_out++;
            if (rotated_q.size() == 0) begin
                $error("result transaction with no expectation: %h", got);
                n_fail++;
            end else begin
                want = rotated_q.pop_front();
                if (got.rx !== want.rx) begin
                    $error("rot_x expected %0d actual %0d", want.rx, got.rx);
                    n_fail++;
                end
                if (got.ry !== want.ry) begin
                    $error("rot_y expected %0d actual %0d", want.ry, got.ry);
                    n_fail++;
                end
                if (got.rz !== want.rz) begin
                    $error("rot_z expected %0d actual %0d", want.rz, got.rz);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row     rows[$];
        t_row     r;
        t_rot_req q;
        int       wait_n;
        n_fail = 0; n_in = 0; n_out = 0;
        rx_enable = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;

        // zero angle about z: identity up to rounding, checked by prediction
        q = '{angle: 0, vz: 32'sh0003_0000, vy: 32'sh0002_0000, vx: 32'sh0001_0000,
              az: 16384, ay: 0, ax: 0};
        r = '{req: q, known: 0, res: '0}; rows.push_back(r);
        // zero vector gives zero whatever the axis and angle
        q = '{angle: 16'sh7fff, vz: 0, vy: 0, vx: 0, az: -16384, ay: 0, ax: 0};
        r = '{req: q, known: 1, res: '0}; rows.push_back(r);
        q = '{angle: 16'sh8000, vz: 0, vy: 0, vx: 0, az: 0, ay: 16384, ax: 0};
        r = '{req: q, known: 1, res: '0}; rows.push_back(r);
        // zero axis with angle near pi flips the vector sign, saturating at extremes
        q = '{angle: 16'sd12868, vz: 32'sh8000_0000, vy: 32'sh7fff_ffff,
              vx: 32'sh8000_0000, az: 0, ay: 0, ax: 0};
        r = '{req: q, known: 1, res: '{rz: 32'sh7fff_ffff, ry: 32'sh8000_0001,
              rx: 32'sh7fff_ffff}}; rows.push_back(r);
        // angle extremes, quarter turns and wrap past pi
        for (int k = 0; k < 10; k++) begin
            q.ax = (k % 3 == 0) ? 16384 : 0;
            q.ay = (k % 3 == 1) ? -16384 : 0;
            q.az = (k % 3 == 2) ? 16384 : 0;
            q.vx = 32'sh7fff_ffff; q.vy = 32'sh8000_0000; q.vz = 32'sh0001_0000;
            case (k)
                0: q.angle = 16'sh7fff;
                1: q.angle = 16'sh8000;
                2: q.angle = 16'sd6434;
                3: q.angle = -16'sd6434;
                4: q.angle = 16'sd6435;
                5: q.angle = -16'sd6435;
                6: q.angle = 16'sd12868;
                7: q.angle = -16'sd12868;
                8: q.angle = 16'sd12869;
                default: q.angle = -16'sd12869;
            endcase
            r = '{req: q, known: 0, res: '0}; rows.push_back(r);
        end
        // non-unit axes with components of +-16384 and a diagonal unit axis
        q = '{angle: 16'sd3000, vz: -32'sd99999, vy: 32'sd123456, vx: -32'sd7,
              az: -16384, ay: -16384, ax: -16384};
        r = '{req: q, known: 0, res: '0}; rows.push_back(r);
        q = '{angle: -16'sd9000, vz: 32'sh7fff_ffff, vy: 32'sh7fff_ffff,
              vx: 32'sh7fff_ffff, az: 16384, ay: 16384, ax: 16384};
        r = '{req: q, known: 0, res: '0}; rows.push_back(r);
        q = '{angle: 16'sd1, vz: -32'sd1, vy: 32'sd1, vx: 32'sh8000_0000,
              az: 9459, ay: 9459, ax: 9459};
        r = '{req: q, known: 0, res: '0}; rows.push_back(r);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;

        // directed table
        foreach (rows[k]) begin
            send_request(rows[k].req,
                         rows[k].known ? rows[k].res : rotate_vector(rows[k].req));
        end

        // random part, pausing once until the pipeline drains
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                i_s_axis_tvalid <= 1'b0;
                while (rotated_q.size() != 0) @(negedge i_clk);
            end
            q.ax = rand_axis(); q.ay = rand_axis(); q.az = rand_axis();
            // unit axes along one direction now and then
            if ($urandom_range(0, 3) == 0) begin
                q.ax = 0; q.ay = 0; q.az = 0;
                case ($urandom_range(0, 2))
                    0: q.ax = $urandom_range(0, 1) ? 16384 : -16384;
                    1: q.ay = $urandom_range(0, 1) ? 16384 : -16384;
                    default: q.az = $urandom_range(0, 1) ? 16384 : -16384;
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                q.vx = $urandom(); q.vy = $urandom(); q.vz = $urandom();
            end else begin
                q.vx = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                q.vy = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
                q.vz = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            end
            q.angle = 16'($urandom());
            send_request(q, rotate_vector(q));
        end
        i_s_axis_tvalid <= 1'b0;

        // drain
        wait_n = 0;
        while (rotated_q.size() != 0 && wait_n < IDLE_LIMIT) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (rotated_q.size() != 0) n_fail++;

        $display("covered %0d requests and %0d rotated results: angle wraps, quarter turns,",
                 n_in, n_out);
        $display("non-unit and zero axes, saturating vectors, random stalls on both sides");
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
